>>> hdl/ate_pkg.sv
// ate_pkg: shared types and constants of the ANSI terminal emulator core.
// Holds the item and result structs, command codes, byte classes and attribute words.
// No dependencies.
`default_nettype none

package ate_pkg;

    localparam logic [7:0] BEL_BYTE   = 8'h07;
    localparam logic [7:0] BS_BYTE    = 8'h08;
    localparam logic [7:0] LF_BYTE    = 8'h0A;
    localparam logic [7:0] CR_BYTE    = 8'h0D;
    localparam logic [7:0] ESC_BYTE   = 8'h1B;
    localparam logic [7:0] FINAL_BIT  = 8'h40;

    localparam int          MAX_RESULTS = 15;
    localparam int          RES_CNT_W   = 4;
    localparam int          CFG_IDX_W   = 2;
    localparam logic [15:0] MODE_CURSOR = 16'd12;

    localparam logic [7:0] COLS_RESET = 8'd80;
    localparam logic [7:0] ROWS_RESET = 8'd25;

    localparam logic [15:0] SGR_RESET     = 16'd0;
    localparam logic [15:0] SGR_BOLD      = 16'd1;
    localparam logic [15:0] SGR_UNDERLINE = 16'd4;
    localparam logic [15:0] SGR_BLINK     = 16'd5;
    localparam logic [15:0] SGR_REVERSE   = 16'd7;
    localparam logic [15:0] SGR_FG_LO     = 16'd30;
    localparam logic [15:0] SGR_FG_HI     = 16'd37;
    localparam logic [15:0] SGR_BG_LO     = 16'd40;
    localparam logic [15:0] SGR_BG_HI     = 16'd47;

    localparam logic [15:0] ATTR_NONE        = 16'h0000;
    localparam logic [15:0] ATTR_REV_CLR_VAL = 16'h0077;
    localparam logic [15:0] ATTR_UL_CLR_VAL  = 16'h0040;
    localparam logic [15:0] ATTR_RESET_MASK  = 16'hff88;
    localparam logic [15:0] ATTR_RESET_VAL   = 16'h0700;
    localparam logic [15:0] ATTR_BOLD_VAL    = 16'h0808;
    localparam logic [15:0] ATTR_UL_MASK     = 16'h7700;
    localparam logic [15:0] ATTR_UL_COL_VAL  = 16'h0100;
    localparam logic [15:0] ATTR_UL_VAL      = 16'h0140;
    localparam logic [15:0] ATTR_BLINK_VAL   = 16'h8080;
    localparam logic [15:0] ATTR_REV_ON_VAL  = 16'h7077;
    localparam logic [15:0] ATTR_REV_OFF_VAL = 16'h0777;
    localparam logic [15:0] ATTR_FG_MASK     = 16'h0007;
    localparam logic [15:0] ATTR_BG_MASK     = 16'h0070;

    typedef enum logic [3:0] {
        CMD_RAW,
        CMD_PUTC,
        CMD_MOVE,
        CMD_CLEAR_SCREEN,
        CMD_CLEAR_EOL,
        CMD_INSERT_LINES,
        CMD_DELETE_LINES,
        CMD_CURSOR_BIG,
        CMD_CURSOR_SMALL,
        CMD_ATTR
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLS,
        CFG_ROWS,
        CFG_EMULATE
    } t_cfg_reg;

    typedef enum logic [4:0] {
        CL_BEL,
        CL_CR,
        CL_LF,
        CL_BS,
        CL_ESC,
        CL_IGNORE,
        CL_SEP,
        CL_DIGIT,
        CL_CUP,
        CL_ED,
        CL_EL,
        CL_IL,
        CL_DL,
        CL_SM,
        CL_RM,
        CL_SGR,
        CL_FINAL,
        CL_PLAIN
    } t_byte_class;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ATTR,
        ST_FLUSH
    } t_back_state;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       final_in_buffer;
    } t_in_item;

    typedef struct packed {
        t_byte_class cls;
        logic [7:0]  ch;
    } t_op;

    typedef struct packed {
        t_cmd        command;
        logic [7:0]  char_out;
        logic [7:0]  cursor_col;
        logic [7:0]  cursor_row;
        logic [15:0] line_count;
        logic [15:0] attr_mask;
        logic [15:0] attr_value;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

>>> hdl/ate_fifo.sv
// ate_fifo: small register-based first-in first-out queue.
// Generic in width and depth; head entry is shown combinationally. No dependencies.
`default_nettype none

module ate_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> hdl/ate_front.sv
// ate_front: accepts bytes, classifies them and queues them for the back end.
// Depends on ate_pkg and ate_fifo.
`default_nettype none

module ate_front import ate_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_in_item i_item,
    input  wire logic     i_push,
    output logic          o_full,
    output t_op           o_op,
    output logic          o_op_valid,
    input  wire logic     i_op_pop
);

    t_op              op_in;
    logic             op_empty;
    logic [$bits(t_op)-1:0] op_bits;

    always_comb begin
        op_in.ch = i_item.byte_in;
        case (i_item.byte_in)
            BEL_BYTE: op_in.cls = CL_BEL;
            CR_BYTE:  op_in.cls = CL_CR;
            LF_BYTE:  op_in.cls = CL_LF;
            BS_BYTE:  op_in.cls = CL_BS;
            ESC_BYTE: op_in.cls = CL_ESC;
            "[":      op_in.cls = CL_IGNORE;
            "?":      op_in.cls = CL_IGNORE;
            ";":      op_in.cls = CL_SEP;
            "H":      op_in.cls = CL_CUP;
            "J":      op_in.cls = CL_ED;
            "K":      op_in.cls = CL_EL;
            "L":      op_in.cls = CL_IL;
            "M":      op_in.cls = CL_DL;
            "h":      op_in.cls = CL_SM;
            "l":      op_in.cls = CL_RM;
            "m":      op_in.cls = CL_SGR;
            default: begin
                if (i_item.byte_in inside {["0":"9"]}) begin
                    op_in.cls = CL_DIGIT;
                end else if ((i_item.byte_in & FINAL_BIT) != 8'h00) begin
                    op_in.cls = CL_FINAL;
                end else begin
                    op_in.cls = CL_PLAIN;
                end
            end
        endcase
    end

    ate_fifo #(
        .WIDTH ($bits(t_op)),
        .DEPTH (DEPTH)
    ) u_op_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (op_in),
        .o_full  (o_full),
        .i_pop   (i_op_pop),
        .o_data  (op_bits),
        .o_empty (op_empty)
    );

    assign o_op       = t_op'(op_bits);
    assign o_op_valid = !op_empty;

endmodule

`default_nettype wire

>>> hdl/ate_back.sv
// ate_back: executes classified bytes, tracks cursor, escape arguments and attributes.
// Emits display commands toward the result queue. Depends on ate_pkg.
`default_nettype none

module ate_back import ate_pkg::*; #(
    parameter int ARG_SLOTS = 5
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [7:0] i_cols,
    input  wire logic [7:0] i_rows,
    input  wire logic       i_emulate,
    input  wire t_op        i_op,
    input  wire logic       i_op_valid,
    output logic            o_op_pop,
    output t_result         o_res,
    output logic            o_res_push,
    input  wire logic       i_res_full
);

    localparam int IDX_W = $clog2(ARG_SLOTS + 1);
    localparam int SEL_W = $clog2(ARG_SLOTS);
    localparam logic [IDX_W-1:0]     IDX_MAX = IDX_W'(ARG_SLOTS);
    localparam logic [RES_CNT_W-1:0] CNT_MAX = RES_CNT_W'(MAX_RESULTS);
    localparam logic [1:0] PH_REVERSE   = 2'd0;
    localparam logic [1:0] PH_UNDERLINE = 2'd1;

    function automatic t_result mk_res(input t_cmd cmd, input logic [7:0] ch,
                                       input logic [7:0] col, input logic [7:0] row,
                                       input logic [15:0] cnt, input logic [15:0] msk,
                                       input logic [15:0] val, input logic last);
        t_result r;
        r.command    = cmd;
        r.char_out   = ch;
        r.cursor_col = col;
        r.cursor_row = row;
        r.line_count = cnt;
        r.attr_mask  = msk;
        r.attr_value = val;
        r.last       = last;
        return r;
    endfunction

    function automatic logic [2:0] fg_code(input logic [2:0] idx);
        logic [2:0] c;
        case (idx)
            3'd0:    c = 3'd0;
            3'd1:    c = 3'd4;
            3'd2:    c = 3'd2;
            3'd3:    c = 3'd6;
            3'd4:    c = 3'd1;
            3'd5:    c = 3'd5;
            3'd6:    c = 3'd3;
            default: c = 3'd7;
        endcase
        return c;
    endfunction

    t_back_state          r_state, n_state;
    logic [15:0]          r_args [ARG_SLOTS];
    logic [15:0]          n_args [ARG_SLOTS];
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [IDX_W-1:0]     r_walk, n_walk;
    logic [1:0]           r_ph, n_ph;
    logic                 r_in_esc, n_in_esc;
    logic [7:0]           r_col, n_col;
    logic [7:0]           r_row, n_row;
    logic                 r_rev, n_rev;
    logic                 r_und, n_und;
    logic                 r_colr, n_colr;
    t_result              r_pend, n_pend;
    logic                 r_pend_v, n_pend_v;
    logic [RES_CNT_W-1:0] r_cnt, n_cnt;

    logic [7:0]       cols, rows, cm1, rm1, col_c, row_c, col_h, row_h;
    logic [15:0]      a0, a1, col_t, row_t, cur_arg, attr_a, fg_off, bg_off;
    logic [19:0]      prod;
    logic [15:0]      dig_val;
    logic [SEL_W-1:0] sel;
    logic             a_emit, a_adv, a_rev, a_und, a_colr;
    logic [15:0]      a_mask, a_val;

    assign cols  = (i_cols == 8'd0) ? 8'd1 : i_cols;
    assign rows  = (i_rows == 8'd0) ? 8'd1 : i_rows;
    assign cm1   = cols - 8'd1;
    assign rm1   = rows - 8'd1;
    assign col_c = (r_col > cm1) ? cm1 : r_col;
    assign row_c = (r_row > rm1) ? rm1 : r_row;

    assign a0    = r_args[0];
    assign a1    = r_args[1];
    assign col_t = (a1 == 16'd0) ? 16'd0 : a1 - 16'd1;
    assign row_t = (a0 == 16'd0) ? 16'd0 : a0 - 16'd1;
    assign col_h = (col_t > {8'd0, cm1}) ? cm1 : col_t[7:0];
    assign row_h = (row_t > {8'd0, rm1}) ? rm1 : row_t[7:0];

    assign sel     = r_idx[SEL_W-1:0];
    assign cur_arg = r_args[sel];
    assign prod    = ({4'd0, cur_arg} << 3) + ({4'd0, cur_arg} << 1)
                   + {16'd0, i_op.ch[3:0]};
    assign dig_val = (prod[19:16] != 4'd0) ? 16'hFFFF : prod[15:0];

    assign attr_a = r_args[0];
    assign fg_off = attr_a - SGR_FG_LO;
    assign bg_off = attr_a - SGR_BG_LO;

    always_comb begin
        a_emit = 1'b0;
        a_adv  = 1'b1;
        a_mask = ATTR_NONE;
        a_val  = ATTR_NONE;
        a_rev  = r_rev;
        a_und  = r_und;
        a_colr = r_colr;
        if (attr_a == SGR_RESET) begin
            case (r_ph)
                PH_REVERSE: begin
                    a_adv = 1'b0;
                    if (r_rev) begin
                        a_emit = 1'b1;
                        a_val  = ATTR_REV_CLR_VAL;
                        a_rev  = 1'b0;
                    end
                end
                PH_UNDERLINE: begin
                    a_adv = 1'b0;
                    if (r_und && !r_colr) begin
                        a_emit = 1'b1;
                        a_val  = ATTR_UL_CLR_VAL;
                        a_und  = 1'b0;
                    end
                end
                default: begin
                    a_colr = 1'b0;
                    a_emit = 1'b1;
                    a_mask = ATTR_RESET_MASK;
                    a_val  = ATTR_RESET_VAL;
                end
            endcase
        end else if (attr_a == SGR_BOLD) begin
            a_emit = 1'b1;
            a_val  = ATTR_BOLD_VAL;
        end else if (attr_a == SGR_UNDERLINE) begin
            a_emit = 1'b1;
            a_mask = ATTR_UL_MASK;
            if (r_colr) begin
                a_val = ATTR_UL_COL_VAL;
            end else begin
                a_und = !r_und;
                a_val = ATTR_UL_VAL;
            end
        end else if (attr_a == SGR_BLINK) begin
            a_emit = 1'b1;
            a_val  = ATTR_BLINK_VAL;
        end else if (attr_a == SGR_REVERSE) begin
            a_emit = 1'b1;
            a_rev  = !r_rev;
            a_mask = ATTR_UL_MASK;
            a_val  = r_rev ? ATTR_REV_OFF_VAL : ATTR_REV_ON_VAL;
        end else if (attr_a >= SGR_FG_LO && attr_a <= SGR_FG_HI) begin
            a_emit = 1'b1;
            a_mask = ATTR_FG_MASK;
            a_val  = {13'd0, fg_code(fg_off[2:0])};
        end else if (attr_a >= SGR_BG_LO && attr_a <= SGR_BG_HI) begin
            a_emit = 1'b1;
            a_mask = ATTR_BG_MASK;
            a_val  = {9'd0, fg_code(bg_off[2:0]), 4'd0};
            a_colr = (attr_a == SGR_BG_HI) ? r_und : 1'b1;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_args     = r_args;
        n_idx      = r_idx;
        n_walk     = r_walk;
        n_ph       = r_ph;
        n_in_esc   = r_in_esc;
        n_col      = r_col;
        n_row      = r_row;
        n_rev      = r_rev;
        n_und      = r_und;
        n_colr     = r_colr;
        n_pend     = r_pend;
        n_pend_v   = r_pend_v;
        n_cnt      = r_cnt;
        o_op_pop   = 1'b0;
        o_res_push = 1'b0;
        o_res      = mk_res(CMD_RAW, 8'd0, 8'd0, 8'd0, 16'd0, ATTR_NONE, ATTR_NONE, 1'b0);
        case (r_state)
            ST_IDLE: begin
                if (i_op_valid && !i_res_full) begin
                    o_op_pop = 1'b1;
                    if (!i_emulate) begin
                        o_res_push = 1'b1;
                        o_res = mk_res(CMD_RAW, i_op.ch, 8'd0, 8'd0, 16'd0,
                                       ATTR_NONE, ATTR_NONE, 1'b1);
                    end else begin
                        n_col = col_c;
                        n_row = row_c;
                        case (i_op.cls)
                            CL_BEL: begin
                                o_res_push = 1'b1;
                                o_res = mk_res(CMD_PUTC, i_op.ch, 8'd0, 8'd0, 16'd0,
                                               ATTR_NONE, ATTR_NONE, 1'b1);
                            end
                            CL_CR: begin
                                n_col      = 8'd0;
                                o_res_push = 1'b1;
                                o_res = mk_res(CMD_MOVE, 8'd0, 8'd0, row_c, 16'd0,
                                               ATTR_NONE, ATTR_NONE, 1'b1);
                            end
                            CL_LF: begin
                                o_res_push = 1'b1;
                                if (row_c < rm1) begin
                                    n_row = row_c + 8'd1;
                                    o_res = mk_res(CMD_MOVE, 8'd0, col_c, row_c + 8'd1,
                                                   16'd0, ATTR_NONE, ATTR_NONE, 1'b1);
                                end else begin
                                    o_res = mk_res(CMD_PUTC, i_op.ch, 8'd0, 8'd0, 16'd0,
                                                   ATTR_NONE, ATTR_NONE, 1'b1);
                                end
                            end
                            CL_BS: begin
                                o_res_push = 1'b1;
                                if (col_c != 8'd0) begin
                                    n_col = col_c - 8'd1;
                                    o_res = mk_res(CMD_MOVE, 8'd0, col_c - 8'd1, row_c,
                                                   16'd0, ATTR_NONE, ATTR_NONE, 1'b1);
                                end else if (row_c != 8'd0) begin
                                    n_col = cm1;
                                    n_row = row_c - 8'd1;
                                    o_res = mk_res(CMD_MOVE, 8'd0, cm1, row_c - 8'd1,
                                                   16'd0, ATTR_NONE, ATTR_NONE, 1'b1);
                                end else begin
                                    o_res = mk_res(CMD_MOVE, 8'd0, col_c, row_c,
                                                   16'd0, ATTR_NONE, ATTR_NONE, 1'b1);
                                end
                            end
                            CL_ESC: begin
                                for (int k = 0; k < ARG_SLOTS; k++) begin
                                    n_args[k] = 16'd0;
                                end
                                n_idx    = '0;
                                n_in_esc = 1'b1;
                            end
                            default: begin
                                if (!r_in_esc) begin
                                    o_res_push = 1'b1;
                                    o_res = mk_res(CMD_PUTC, i_op.ch, 8'd0, 8'd0, 16'd0,
                                                   ATTR_NONE, ATTR_NONE, 1'b1);
                                    if (col_c == cm1) begin
                                        n_col = 8'd0;
                                        if (row_c < rm1) begin
                                            n_row = row_c + 8'd1;
                                        end
                                    end else begin
                                        n_col = col_c + 8'd1;
                                    end
                                end else begin
                                    case (i_op.cls)
                                        CL_SEP: begin
                                            if (r_idx < IDX_MAX) begin
                                                n_idx = r_idx + 1'b1;
                                            end
                                        end
                                        CL_DIGIT: begin
                                            if (r_idx < IDX_MAX) begin
                                                n_args[sel] = dig_val;
                                            end
                                        end
                                        CL_CUP: begin
                                            n_col      = col_h;
                                            n_row      = row_h;
                                            n_in_esc   = 1'b0;
                                            o_res_push = 1'b1;
                                            o_res = mk_res(CMD_MOVE, 8'd0, col_h, row_h,
                                                           16'd0, ATTR_NONE, ATTR_NONE,
                                                           1'b1);
                                        end
                                        CL_ED: begin
                                            n_in_esc   = 1'b0;
                                            o_res_push = 1'b1;
                                            o_res = mk_res(CMD_CLEAR_SCREEN, 8'd0, 8'd0,
                                                           8'd0, 16'd0, ATTR_NONE,
                                                           ATTR_NONE, 1'b1);
                                        end
                                        CL_EL: begin
                                            n_in_esc   = 1'b0;
                                            o_res_push = 1'b1;
                                            o_res = mk_res(CMD_CLEAR_EOL, 8'd0, 8'd0,
                                                           8'd0, 16'd0, ATTR_NONE,
                                                           ATTR_NONE, 1'b1);
                                        end
                                        CL_IL, CL_DL: begin
                                            n_in_esc   = 1'b0;
                                            o_res_push = 1'b1;
                                            o_res = mk_res((i_op.cls == CL_IL) ?
                                                           CMD_INSERT_LINES :
                                                           CMD_DELETE_LINES,
                                                           8'd0, 8'd0, 8'd0,
                                                           (a0 == 16'd0) ? 16'd1 : a0,
                                                           ATTR_NONE, ATTR_NONE, 1'b1);
                                        end
                                        CL_SM, CL_RM: begin
                                            n_in_esc = 1'b0;
                                            if (a0 == MODE_CURSOR) begin
                                                o_res_push = 1'b1;
                                                o_res = mk_res((i_op.cls == CL_SM) ?
                                                               CMD_CURSOR_BIG :
                                                               CMD_CURSOR_SMALL,
                                                               8'd0, 8'd0, 8'd0, 16'd0,
                                                               ATTR_NONE, ATTR_NONE,
                                                               1'b1);
                                            end
                                        end
                                        CL_SGR: begin
                                            n_in_esc = 1'b0;
                                            n_walk   = (r_idx < IDX_MAX) ?
                                                       r_idx + 1'b1 : IDX_MAX;
                                            n_ph     = PH_REVERSE;
                                            n_cnt    = '0;
                                            n_pend_v = 1'b0;
                                            n_state  = ST_ATTR;
                                        end
                                        CL_FINAL: begin
                                            n_in_esc = 1'b0;
                                        end
                                        default: begin
                                        end
                                    endcase
                                end
                            end
                        endcase
                    end
                end
            end
            ST_ATTR: begin
                if (!i_res_full) begin
                    n_rev  = a_rev;
                    n_und  = a_und;
                    n_colr = a_colr;
                    if (a_emit && r_cnt < CNT_MAX) begin
                        if (r_pend_v) begin
                            o_res_push = 1'b1;
                            o_res      = r_pend;
                        end
                        n_pend   = mk_res(CMD_ATTR, 8'd0, 8'd0, 8'd0, 16'd0,
                                          a_mask, a_val, 1'b0);
                        n_pend_v = 1'b1;
                        n_cnt    = r_cnt + 1'b1;
                    end
                    if (a_adv) begin
                        for (int k = 0; k < ARG_SLOTS - 1; k++) begin
                            n_args[k] = r_args[k+1];
                        end
                        n_args[ARG_SLOTS-1] = 16'd0;
                        n_walk = r_walk - 1'b1;
                        n_ph   = PH_REVERSE;
                        if (r_walk == IDX_W'(1)) begin
                            n_state = ST_FLUSH;
                        end
                    end else begin
                        n_ph = r_ph + 2'd1;
                    end
                end
            end
            ST_FLUSH: begin
                if (!r_pend_v) begin
                    n_state = ST_IDLE;
                end else if (!i_res_full) begin
                    o_res_push = 1'b1;
                    o_res      = r_pend;
                    o_res.last = 1'b1;
                    n_pend_v   = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            for (int k = 0; k < ARG_SLOTS; k++) begin
                r_args[k] <= 16'd0;
            end
            r_idx    <= '0;
            r_walk   <= '0;
            r_ph     <= PH_REVERSE;
            r_in_esc <= 1'b0;
            r_col    <= 8'd0;
            r_row    <= 8'd0;
            r_rev    <= 1'b0;
            r_und    <= 1'b0;
            r_colr   <= 1'b0;
            r_pend_v <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_args   <= n_args;
            r_idx    <= n_idx;
            r_walk   <= n_walk;
            r_ph     <= n_ph;
            r_in_esc <= n_in_esc;
            r_col    <= n_col;
            r_row    <= n_row;
            r_rev    <= n_rev;
            r_und    <= n_und;
            r_colr   <= n_colr;
            r_pend_v <= n_pend_v;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
    end

endmodule

`default_nettype wire

>>> hdl/ansi_terminal_emulator_core.sv
// Path: a byte is registered in the operation queue, executed by the back end as it leaves,
// and its result registered in the result queue; an 'm' byte holds each attribute result
// until the next one pushes it out and queues the last at the walk's end. Throughput: one byte
// per cycle while the result queue has room and no 'm' attribute walk or flush is running.
// Reset (synchronous, active low) empties both queues, homes the cursor, closes any escape,
// clears attributes, restores 80 columns, 25 rows, emulation on. Uses ate_pkg, ate_fifo, front, back.
`default_nettype none

module ansi_terminal_emulator_core import ate_pkg::*; #(
    parameter int ARG_SLOTS = 5,
    parameter int OP_DEPTH  = 2,
    parameter int RES_DEPTH = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire t_in_item             i_data,
    output logic                      empty,
    input  wire logic                 pop,
    output t_result                   o_data,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]           i_cfg_data
);

    logic [7:0] r_cols;
    logic [7:0] r_rows;
    logic       r_emulate;
    t_op        op;
    logic       op_valid, op_pop;
    t_result    res;
    logic       res_push, res_full;
    logic [$bits(t_result)-1:0] res_bits;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols    <= COLS_RESET;
            r_rows    <= ROWS_RESET;
            r_emulate <= 1'b1;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_COLS:    r_cols    <= i_cfg_data;
                CFG_ROWS:    r_rows    <= i_cfg_data;
                CFG_EMULATE: r_emulate <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    ate_front #(
        .DEPTH (OP_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_data),
        .i_push     (push),
        .o_full     (full),
        .o_op       (op),
        .o_op_valid (op_valid),
        .i_op_pop   (op_pop)
    );

    ate_back #(
        .ARG_SLOTS (ARG_SLOTS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cols     (r_cols),
        .i_rows     (r_rows),
        .i_emulate  (r_emulate),
        .i_op       (op),
        .i_op_valid (op_valid),
        .o_op_pop   (op_pop),
        .o_res      (res),
        .o_res_push (res_push),
        .i_res_full (res_full)
    );

    ate_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RES_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_bits),
        .o_empty (empty)
    );

    assign o_data = t_result'(res_bits);

endmodule

`default_nettype wire

>>> hdl/ate_checker.sv
// ate_checker: port-level assertions for ansi_terminal_emulator_core, bound to the top.
// Depends on ate_pkg.
`default_nettype none

module ate_checker import ate_pkg::*; (
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    full,
    input wire logic    empty,
    input wire logic    pop,
    input wire t_result o_data
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_data))
        else $error("waiting result changed before pop");

    a_move_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_data.command != CMD_MOVE
        |-> o_data.cursor_col == 8'd0 && o_data.cursor_row == 8'd0)
        else $error("cursor fields set on a non-move transaction");

    a_char_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_data.command != CMD_RAW && o_data.command != CMD_PUTC
        |-> o_data.char_out == 8'd0)
        else $error("character set on a non-character transaction");

    a_line_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (o_data.command == CMD_INSERT_LINES || o_data.command == CMD_DELETE_LINES)
        |-> o_data.line_count != 16'd0)
        else $error("zero line count on insert or delete");

endmodule

bind ansi_terminal_emulator_core ate_checker u_ate_checker (.*);

`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for ansi_terminal_emulator_core: a predictor of cursor, escape
// parser and attribute flags turns each accepted byte into the display commands it causes.
// Depends on ate_pkg and the core; drives bursts of bytes, stalls pop, walks screen settings.
`timescale 1ns / 100ps

module testbench import ate_pkg::*;;

    localparam int NUM_ARGS      = 5;
    localparam int SETTLE_CYCLES = 40;
    localparam logic [7:0]  CTL_BYTES[4] = '{BEL_BYTE, CR_BYTE, LF_BYTE, BS_BYTE};
    localparam logic [15:0] SGR_PLAIN[5] = '{SGR_RESET, SGR_BOLD, SGR_UNDERLINE, SGR_BLINK,
                                             SGR_REVERSE};

    typedef struct {
        logic [7:0]  cols;
        logic [7:0]  rows;
        logic        emu;
        int unsigned n_bytes;
    } t_phase;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 push        = 1'b0;
    logic                 full;
    t_in_item             i_data      = '0;
    logic                 empty;
    logic                 pop         = 1'b0;
    t_result              o_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [7:0]           i_cfg_data  = '0;

    int unsigned n_sent     = 0;
    int unsigned burst_left = 0;
    logic [7:0]  pop_pat    = 8'hff;
    int unsigned pop_age    = 0;

    class screen_scoreboard;
        logic [7:0]  n_cols;
        logic [7:0]  n_rows;
        logic        emu;
        logic [15:0] arg_val[NUM_ARGS];
        int unsigned arg_pos;
        logic        esc_open;
        int unsigned col;
        int unsigned row;
        logic        rev_on;
        logic        ul_on;
        logic        color_on;
        t_result     fresh[$];
        t_result     pending_cmds[$];
        int          errors;

        function new();
            n_cols   = COLS_RESET;
            n_rows   = ROWS_RESET;
            emu      = 1'b1;
            foreach (arg_val[i]) arg_val[i] = '0;
            arg_pos  = 0;
            esc_open = 1'b0;
            col      = 0;
            row      = 0;
            rev_on   = 1'b0;
            ul_on    = 1'b0;
            color_on = 1'b0;
            errors   = 0;
        endfunction

        function void set_reg(t_cfg_reg idx, logic [7:0] val);
            case (idx)
                CFG_COLS:    n_cols = val;
                CFG_ROWS:    n_rows = val;
                CFG_EMULATE: emu = val[0];
                default: ;
            endcase
        endfunction

        function void add(t_cmd cmd, logic [7:0] ch, int unsigned cc, int unsigned cr,
                          int unsigned cnt, logic [15:0] msk, logic [15:0] val);
            t_result r;
            if (fresh.size() >= MAX_RESULTS) return;
            r.command    = cmd;
            r.char_out   = ch;
            r.cursor_col = 8'(cc);
            r.cursor_row = 8'(cr);
            r.line_count = 16'(cnt);
            r.attr_mask  = msk;
            r.attr_value = val;
            r.last       = 1'b0;
            fresh.push_back(r);
        endfunction

        function logic [15:0] rev3(int unsigned x);
            return {13'd0, x[0], x[1], x[2]};
        endfunction

        function void note_byte(t_in_item item);
            logic [7:0]  c;
            int unsigned cw, rw, a0, a1, v;
            c = item.byte_in;
            fresh.delete();
            cw = (n_cols == 0) ? 1 : n_cols;
            rw = (n_rows == 0) ? 1 : n_rows;
            if (!emu) begin
                add(CMD_RAW, c, 0, 0, 0, ATTR_NONE, ATTR_NONE);
            end else begin
                if (col > cw - 1) col = cw - 1;
                if (row > rw - 1) row = rw - 1;
                a0 = arg_val[0];
                a1 = arg_val[1];
                if (c == BEL_BYTE) begin
                    add(CMD_PUTC, c, 0, 0, 0, ATTR_NONE, ATTR_NONE);
                end else if (c == CR_BYTE) begin
                    col = 0;
                    add(CMD_MOVE, 8'h00, col, row, 0, ATTR_NONE, ATTR_NONE);
                end else if (c == LF_BYTE) begin
                    if (row < rw - 1) begin
                        row++;
                        add(CMD_MOVE, 8'h00, col, row, 0, ATTR_NONE, ATTR_NONE);
                    end else begin
                        add(CMD_PUTC, c, 0, 0, 0, ATTR_NONE, ATTR_NONE);
                    end
                end else if (c == BS_BYTE) begin
                    if (col > 0) begin
                        col--;
                    end else if (row > 0) begin
                        col = cw - 1;
                        row--;
                    end
                    add(CMD_MOVE, 8'h00, col, row, 0, ATTR_NONE, ATTR_NONE);
                end else if (c == ESC_BYTE) begin
                    foreach (arg_val[i]) arg_val[i] = '0;
                    arg_pos  = 0;
                    esc_open = 1'b1;
                end else if (!esc_open) begin
                    add(CMD_PUTC, c, 0, 0, 0, ATTR_NONE, ATTR_NONE);
                    col++;
                    if (col >= cw) begin
                        col = 0;
                        if (row < rw - 1) row++;
                    end
                end else if (c == "[" || c == "?") begin
                end else if (c == ";") begin
                    if (arg_pos < NUM_ARGS) arg_pos++;
                end else if (c >= "0" && c <= "9") begin
                    if (arg_pos < NUM_ARGS) begin
                        v = 32'(arg_val[arg_pos]) * 10 + 32'(c[3:0]);
                        arg_val[arg_pos] = (v > 65535) ? 16'hffff : 16'(v);
                    end
                end else if (c == "H") begin
                    col = (a1 != 0) ? a1 - 1 : 0;
                    row = (a0 != 0) ? a0 - 1 : 0;
                    if (col > cw - 1) col = cw - 1;
                    if (row > rw - 1) row = rw - 1;
                    add(CMD_MOVE, 8'h00, col, row, 0, ATTR_NONE, ATTR_NONE);
                    esc_open = 1'b0;
                end else if (c == "J") begin
                    add(CMD_CLEAR_SCREEN, 8'h00, 0, 0, 0, ATTR_NONE, ATTR_NONE);
                    esc_open = 1'b0;
                end else if (c == "K") begin
                    add(CMD_CLEAR_EOL, 8'h00, 0, 0, 0, ATTR_NONE, ATTR_NONE);
                    esc_open = 1'b0;
                end else if (c == "L" || c == "M") begin
                    add((c == "L") ? CMD_INSERT_LINES : CMD_DELETE_LINES, 8'h00, 0, 0,
                        (a0 != 0) ? a0 : 1, ATTR_NONE, ATTR_NONE);
                    esc_open = 1'b0;
                end else if (c == "h" || c == "l") begin
                    if (a0 == MODE_CURSOR)
                        add((c == "h") ? CMD_CURSOR_BIG : CMD_CURSOR_SMALL, 8'h00, 0, 0, 0,
                            ATTR_NONE, ATTR_NONE);
                    esc_open = 1'b0;
                end else if (c == "m") begin
                    for (int j = 0; j <= arg_pos && j < NUM_ARGS; j++) begin
                        v = arg_val[j];
                        if (v == SGR_RESET) begin
                            if (rev_on) begin
                                add(CMD_ATTR, 8'h00, 0, 0, 0, ATTR_NONE, ATTR_REV_CLR_VAL);
                                rev_on = 1'b0;
                            end
                            if (ul_on && !color_on) begin
                                add(CMD_ATTR, 8'h00, 0, 0, 0, ATTR_NONE, ATTR_UL_CLR_VAL);
                                ul_on = 1'b0;
                            end
                            color_on = 1'b0;
                            add(CMD_ATTR, 8'h00, 0, 0, 0, ATTR_RESET_MASK, ATTR_RESET_VAL);
                        end else if (v == SGR_BOLD) begin
                            add(CMD_ATTR, 8'h00, 0, 0, 0, ATTR_NONE, ATTR_BOLD_VAL);
                        end else if (v == SGR_UNDERLINE) begin
                            if (color_on) begin
                                add(CMD_ATTR, 8'h00, 0, 0, 0, ATTR_UL_MASK, ATTR_UL_COL_VAL);
                            end else begin
                                ul_on = !ul_on;
                                add(CMD_ATTR, 8'h00, 0, 0, 0, ATTR_UL_MASK, ATTR_UL_VAL);
                            end
                        end else if (v == SGR_BLINK) begin
                            add(CMD_ATTR, 8'h00, 0, 0, 0, ATTR_NONE, ATTR_BLINK_VAL);
                        end else if (v == SGR_REVERSE) begin
                            rev_on = !rev_on;
                            add(CMD_ATTR, 8'h00, 0, 0, 0, ATTR_UL_MASK,
                                rev_on ? ATTR_REV_ON_VAL : ATTR_REV_OFF_VAL);
                        end else if (v >= SGR_FG_LO && v <= SGR_FG_HI) begin
                            add(CMD_ATTR, 8'h00, 0, 0, 0, ATTR_FG_MASK, rev3(v - SGR_FG_LO));
                        end else if (v >= SGR_BG_LO && v <= SGR_BG_HI) begin
                            add(CMD_ATTR, 8'h00, 0, 0, 0, ATTR_BG_MASK,
                                rev3(v - SGR_BG_LO) << 4);
                            color_on = (v == SGR_BG_HI) ? ul_on : 1'b1;
                        end
                    end
                    esc_open = 1'b0;
                end else if ((c & FINAL_BIT) != 0) begin
                    esc_open = 1'b0;
                end
            end
            if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
            foreach (fresh[i]) pending_cmds.push_back(fresh[i]);
        endfunction

        function void same(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                errors++;
                if (errors <= 200)
                    $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
            end
        endfunction

        function void check_command(t_result got);
            t_result want;
            if (pending_cmds.size() == 0) begin
                errors++;
                if (errors <= 200)
                    $display("%0t: unexpected command, expected none actual %h", $time, got);
                return;
            end
            want = pending_cmds.pop_front();
            same("command", 16'(want.command), 16'(got.command));
            same("char_out", 16'(want.char_out), 16'(got.char_out));
            same("cursor_col", 16'(want.cursor_col), 16'(got.cursor_col));
            same("cursor_row", 16'(want.cursor_row), 16'(got.cursor_row));
            same("line_count", want.line_count, got.line_count);
            same("attr_mask", want.attr_mask, got.attr_mask);
            same("attr_value", want.attr_value, got.attr_value);
            same("last", 16'(want.last), 16'(got.last));
        endfunction
    endclass

    screen_scoreboard sb = new();

    ansi_terminal_emulator_core #(
        .ARG_SLOTS(NUM_ARGS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_data      (i_data),
        .empty       (empty),
        .pop         (pop),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) sb.check_command(o_data);
        if (pop_age == 0) begin
            pop_age = $urandom_range(16, 96);
            pop_pat = ($urandom_range(0, 3) == 0) ? 8'hff : (8'($urandom) | 8'h01);
        end
        pop_age--;
        pop_pat = {pop_pat[0], pop_pat[7:1]};
        pop <= pop_pat[0];
    end

    task automatic send_byte(logic [7:0] b);
        t_in_item    item;
        int unsigned gap;
        item.byte_in         = b;
        item.final_in_buffer = 1'($urandom_range(0, 1));
        push   <= 1'b1;
        i_data <= item;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_byte(item);
        n_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic write_cfg(t_cfg_reg idx, logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (sb.pending_cmds.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random(int unsigned count);
        int unsigned stop, k, n_args, r;
        string       s;
        string       finals;
        finals = "HJKLMhlm";
        stop   = n_sent + count;
        while (n_sent < stop) begin
            k = $urandom_range(0, 99);
            s = "";
            if (k < 55) begin
                s = "\033";
                if ($urandom_range(0, 9) < 7) s = {s, "["};
                if ($urandom_range(0, 7) == 0) s = {s, "?"};
                n_args = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 8)
                                                     : $urandom_range(0, 3);
                for (int i = 0; i < n_args; i++) begin
                    if (i > 0) s = {s, ";"};
                    case ($urandom_range(0, 9))
                        0: ;
                        1, 2: s = $sformatf("%s%0d", s, SGR_PLAIN[$urandom_range(0, 4)]);
                        3: s = $sformatf("%s%0d", s, SGR_FG_LO + $urandom_range(0, 7));
                        4: s = $sformatf("%s%0d", s, SGR_BG_LO + $urandom_range(0, 7));
                        5: s = $sformatf("%s%0d", s, MODE_CURSOR);
                        6: s = $sformatf("%s%0d", s, $urandom_range(0, 300));
                        7: s = $sformatf("%s%0d", s, $urandom_range(65000, 999999));
                        default: s = $sformatf("%s%0d", s, $urandom_range(1, 30));
                    endcase
                    if ($urandom_range(0, 15) == 0)
                        s = $sformatf("%s%c", s, CTL_BYTES[$urandom_range(0, 3)]);
                end
                r = $urandom_range(0, 19);
                if (r < 16) begin
                    r = $urandom_range(0, 7);
                    s = {s, finals.substr(r, r)};
                end else if (r < 18) begin
                    s = $sformatf("%s%c", s, 8'($urandom) | FINAL_BIT);
                end else if (r == 18) begin
                    s = {s, "\033[m"};
                end
                send_text(s);
            end else if (k < 85) begin
                n_args = $urandom_range(1, 12);
                for (int i = 0; i < n_args; i++) begin
                    if ($urandom_range(0, 7) == 0)
                        s = $sformatf("%s%c", s, CTL_BYTES[$urandom_range(0, 3)]);
                    else
                        s = $sformatf("%s%c", s, 8'($urandom_range(8'h20, 8'h7e)));
                end
                send_text(s);
            end else begin
                send_byte(8'($urandom));
            end
        end
    endtask

    initial begin
        t_phase plan[7];
        plan = '{'{8'd80, 8'd25, 1'b1, 30}, '{8'd1, 8'd1, 1'b1, 20},
                 '{8'd0, 8'd0, 1'b1, 15}, '{8'd255, 8'd255, 1'b1, 30},
                 '{8'd7, 8'd4, 1'b1, 25}, '{8'd33, 8'd12, 1'b0, 20},
                 '{8'd12, 8'd3, 1'b1, 30}};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_text("A\015\012\010\007");
        send_byte(8'h00);
        send_byte(8'hff);
        send_text("\033[7;4;0m\03370000H");

        foreach (plan[p]) begin
            drain();
            write_cfg(CFG_COLS, plan[p].cols);
            write_cfg(CFG_ROWS, plan[p].rows);
            write_cfg(CFG_EMULATE, {7'd0, plan[p].emu});
            i_cfg_valid <= 1'b0;
            run_random(plan[p].n_bytes);
            send_text("\033[240;250H");
        end
        drain();

        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
hdl/ate_pkg.sv
hdl/ate_fifo.sv
hdl/ate_front.sv
hdl/ate_back.sv
hdl/ansi_terminal_emulator_core.sv
hdl/ate_checker.sv
test/testbench.sv
